// ===== rtl/core/ttrr_pkg.sv =====
// Shared types and constants for the task table round robin scheduler.
// Depends on nothing; ttrr_ctrl, ttrr_dp and the top level import it.
`timescale 1ns / 1ps
`default_nettype none
package ttrr_pkg;

  localparam int OP_W = 5;
  localparam int GRP_W = 8;
  localparam int TGT_W = 4;
  localparam int DLY_W = 8;
  localparam int FLG_W = 8;
  localparam int ARG_W = 16;
  localparam int STS_W = 3;
  localparam int SLOTO_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GROUP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROT_MASK = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT = 5'd0, OP_CREATE = 5'd1, OP_CREATE_ONCE = 5'd2, OP_RECREATE = 5'd3,
    OP_FIND = 5'd4, OP_KILL_GROUP = 5'd5, OP_KILL_SLOT = 5'd6, OP_KILL_ALL = 5'd7,
    OP_SLEEP = 5'd8, OP_EXIT = 5'd9, OP_SET_GROUP = 5'd10, OP_SET_FLAGS = 5'd11,
    OP_CLEAR_FLAGS = 5'd12, OP_SET_ARG = 5'd13, OP_GET_ARG = 5'd14,
    OP_DISPATCH = 5'd15, OP_TICK = 5'd16
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK = 3'd0, STS_NO_FREE = 3'd1, STS_NO_CURRENT = 3'd2, STS_KILL_CURRENT = 3'd3,
    STS_KILL_FAILED = 3'd4, STS_NOT_FOUND = 3'd5, STS_WAIT_TICK = 3'd6
  } status_t;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_SLEEP = 2'd2;

  // One input word.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [GRP_W-1:0] group_id;
    logic [TGT_W-1:0] target_slot;
    logic [DLY_W-1:0] delay_ticks;
    logic [FLG_W-1:0] flag_bits;
    logic [ARG_W-1:0] arg_in;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [SLOTO_W-1:0] slot;
    logic matched;
    logic [ARG_W-1:0] arg_out;
  } out_word_t;

  // Scan commands from the controller to the datapath.
  typedef enum logic [2:0] {
    SC_NONE, SC_LOAD, SC_FREE, SC_GROUP, SC_VICTIM, SC_RECRE, SC_KILLALL, SC_DISP
  } scan_t;

  typedef struct packed {
    logic load;          // latch the input word, set the scan start index
    logic first;         // non-scanning op or early error result at the first step
    scan_t scan;         // per-slot action this cycle
    logic step;          // advance scan index
  } dp_cmd_t;

  typedef struct packed {
    logic last;          // scan index is at the last slot
    logic hit;           // slot at scan index satisfies the scan test
    logic found;         // a hit has been recorded in the recreate scan
    logic fatal;         // early check failed for this op
    logic disp_wrap;     // dispatch meets table end with no tick since the pass began
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/ttrr_if.sv =====
// Valid/ready channel interface carrying one word.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps
`default_nettype none
interface ttrr_if #(parameter type word_t = logic) (input wire logic clk);
  logic valid;
  logic ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ttrr_ctrl.sv =====
// Controller for the scheduler: sequences single-step ops and slot scans.
// Depends on ttrr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module ttrr_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic [ttrr_pkg::OP_W-1:0] in_op,
  input  wire logic out_free,
  input  wire ttrr_pkg::dp_sts_t sts,
  output ttrr_pkg::dp_cmd_t cmd,
  output logic busy,
  output logic done
);
  import ttrr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_FIRST, S_SCAN1, S_SCAN2, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;

  // Which scan each op needs first.
  function automatic scan_t scan_a(input logic [OP_W-1:0] op);
    case (op)
      OP_CREATE, OP_CREATE_ONCE: scan_a = (op == OP_CREATE_ONCE) ? SC_GROUP : SC_FREE;
      OP_RECREATE: scan_a = SC_RECRE;
      OP_FIND: scan_a = SC_GROUP;
      OP_KILL_GROUP: scan_a = SC_VICTIM;
      OP_KILL_ALL: scan_a = SC_KILLALL;
      OP_DISPATCH: scan_a = SC_DISP;
      default: scan_a = SC_NONE;
    endcase
  endfunction

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cmd = '0;
    cmd.scan = SC_NONE;
    done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          op_nxt = in_op;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        // Non-scanning ops execute here; scanning ops check early errors.
        if (scan_a(op_r) == SC_NONE || sts.fatal) begin
          cmd.first = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan = scan_a(op_r);
        cmd.step = 1'b1;
        if (op_r == OP_DISPATCH) begin
          if (sts.disp_wrap || sts.hit) state_nxt = S_DONE;
        end else if ((op_r == OP_CREATE_ONCE && sts.hit) ||
                     ((op_r == OP_FIND || op_r == OP_CREATE) && sts.hit)) begin
          state_nxt = S_DONE;
        end else if (sts.last) begin
          if (op_r == OP_CREATE_ONCE) state_nxt = S_SCAN2;
          else if (op_r == OP_RECREATE) state_nxt = (sts.found || sts.hit) ? S_SCAN2 : S_DONE;
          else state_nxt = S_DONE;
        end
      end
      S_SCAN2: begin
        // Second scan: free-slot search, for create once and recreate.
        cmd.scan = SC_FREE;
        cmd.step = 1'b1;
        if (sts.hit || sts.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= '0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/ttrr_dp.sv =====
// Datapath for the scheduler: slot table, scan index and result assembly.
// Depends on ttrr_pkg for the words, codes and control structs.
`timescale 1ns / 1ps
`default_nettype none
module ttrr_dp #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ttrr_pkg::in_word_t in_word,
  input  wire ttrr_pkg::dp_cmd_t cmd,
  input  wire logic cfg_we,
  input  wire logic [ttrr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ttrr_pkg::CFG_DATA_W-1:0] cfg_data,
  output ttrr_pkg::dp_sts_t sts,
  output ttrr_pkg::out_word_t res
);
  import ttrr_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int PW = IW + 1;
  localparam logic [PW-1:0] END_POS = PW'(SLOT_COUNT);
  localparam logic [IW-1:0] LAST_I = IW'(SLOT_COUNT - 1);

  logic [1:0] stat_r [SLOT_COUNT];
  logic [1:0] stat_nxt [SLOT_COUNT];
  logic [GRP_W-1:0] grp_r [SLOT_COUNT];
  logic [GRP_W-1:0] grp_nxt [SLOT_COUNT];
  logic [FLG_W-1:0] flg_r [SLOT_COUNT];
  logic [FLG_W-1:0] flg_nxt [SLOT_COUNT];
  logic [DLY_W-1:0] dly_r [SLOT_COUNT];
  logic [DLY_W-1:0] dly_nxt [SLOT_COUNT];
  logic [DLY_W-1:0] sst_r [SLOT_COUNT];
  logic [DLY_W-1:0] sst_nxt [SLOT_COUNT];
  logic [ARG_W-1:0] arg_r [SLOT_COUNT];
  logic [ARG_W-1:0] arg_nxt [SLOT_COUNT];

  logic cv_r, cv_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] scan_r, scan_nxt;
  logic [7:0] tick_r, tick_nxt, pst_r, pst_nxt;
  logic [7:0] fgrp_r, fgrp_nxt, pmask_r, pmask_nxt;
  in_word_t w_r, w_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic found_r, found_nxt;
  out_word_t res_r, res_nxt;

  logic is_cur, tgt_ok, cur_live, sl_free, victim, wake, hit, disp_end;
  logic [7:0] elapsed;
  logic [PW-1:0] tgt_ext;
  logic [IW-1:0] tgt_i;

  // Per-index tests at the scan position.
  always_comb begin
    tgt_ext = PW'(w_r.target_slot);
    tgt_i = tgt_ext[IW-1:0];
    tgt_ok = (w_r.target_slot <= TGT_W'(SLOT_COUNT - 1)) && (tgt_ext < END_POS);
    is_cur = cv_r && (cur_r == idx_r);
    sl_free = (stat_r[idx_r] == ST_FREE);
    victim = !is_cur && !sl_free && (grp_r[idx_r] == w_r.group_id);
    cur_live = cv_r && (stat_r[cur_r] != ST_FREE) && (grp_r[cur_r] == w_r.group_id);
    elapsed = tick_r - sst_r[idx_r];
    wake = (stat_r[idx_r] == ST_SLEEP) && (elapsed >= dly_r[idx_r]);
    // Dispatch stops at table end if no tick has passed since the pass began.
    disp_end = (scan_r == END_POS) && (tick_r == pst_r);
    unique case (cmd.scan)
      SC_FREE: hit = sl_free && !is_cur;
      SC_GROUP: hit = !sl_free && (grp_r[idx_r] == w_r.group_id);
      SC_VICTIM: hit = victim;
      SC_KILLALL: hit = !is_cur && !sl_free;
      SC_RECRE: hit = !is_cur && (sl_free || victim);
      SC_DISP: hit = !disp_end && (scan_r != END_POS || 1'b1) &&
                     ((stat_r[idx_r] == ST_READY) || wake);
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    sts.last = (idx_r == LAST_I);
    sts.hit = hit;
    sts.found = found_r;
    sts.disp_wrap = disp_end;
    unique case (w_r.op)
      OP_RECREATE: sts.fatal = cur_live;
      default: sts.fatal = 1'b0;
    endcase
  end

  // Main next-state logic.
  always_comb begin
    stat_nxt = stat_r; grp_nxt = grp_r; flg_nxt = flg_r; dly_nxt = dly_r;
    sst_nxt = sst_r; arg_nxt = arg_r;
    cv_nxt = cv_r; cur_nxt = cur_r; scan_nxt = scan_r; tick_nxt = tick_r;
    pst_nxt = pst_r; fgrp_nxt = fgrp_r; pmask_nxt = pmask_r; w_nxt = w_r;
    idx_nxt = idx_r; found_nxt = found_r; res_nxt = res_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FIRST_GROUP: fgrp_nxt = cfg_data;
        CFG_PROT_MASK: pmask_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.load) begin
      w_nxt = in_word;
      idx_nxt = '0;
      found_nxt = 1'b0;
      res_nxt = '0;
      // Dispatch starting below table end opens a new pass.
      if (in_word.op == OP_DISPATCH) begin
        if (scan_r != END_POS) pst_nxt = tick_r;
        idx_nxt = (scan_r == END_POS) ? '0 : scan_r[IW-1:0];
      end
    end

    // Non-scanning ops and early error results.
    if (cmd.first) begin
      unique case (w_r.op)
        OP_INIT: begin
          for (int k = 0; k < SLOT_COUNT; k++) begin
            stat_nxt[k] = ST_FREE; grp_nxt[k] = '0; flg_nxt[k] = '0;
            dly_nxt[k] = '0; sst_nxt[k] = '0; arg_nxt[k] = '0;
          end
          stat_nxt[0] = ST_READY;
          grp_nxt[0] = fgrp_r;
          cv_nxt = 1'b1; cur_nxt = '0; scan_nxt = END_POS; pst_nxt = tick_r;
        end
        OP_RECREATE: res_nxt.status = STS_KILL_FAILED;
        OP_KILL_SLOT: begin
          if (!tgt_ok) res_nxt.status = STS_KILL_FAILED;
          else if (cv_r && cur_r == tgt_i) res_nxt.status = STS_KILL_CURRENT;
          else begin
            stat_nxt[tgt_i] = ST_FREE;
            grp_nxt[tgt_i] = '0;
          end
        end
        OP_SLEEP, OP_EXIT, OP_SET_GROUP, OP_SET_FLAGS, OP_CLEAR_FLAGS, OP_GET_ARG: begin
          if (!cv_r) res_nxt.status = STS_NO_CURRENT;
          else begin
            unique case (w_r.op)
              OP_SLEEP: begin
                dly_nxt[cur_r] = w_r.delay_ticks; sst_nxt[cur_r] = tick_r;
                stat_nxt[cur_r] = ST_SLEEP;
              end
              OP_EXIT: begin stat_nxt[cur_r] = ST_FREE; cv_nxt = 1'b0; end
              OP_SET_GROUP: grp_nxt[cur_r] = w_r.group_id;
              OP_SET_FLAGS: flg_nxt[cur_r] = flg_r[cur_r] | w_r.flag_bits;
              OP_CLEAR_FLAGS: flg_nxt[cur_r] = flg_r[cur_r] & ~w_r.flag_bits;
              default: res_nxt.arg_out = arg_r[cur_r];
            endcase
          end
        end
        OP_SET_ARG: begin
          if (!tgt_ok) res_nxt.status = STS_NOT_FOUND;
          else arg_nxt[tgt_i] = w_r.arg_in;
        end
        OP_TICK: tick_nxt = tick_r + 8'd1;
        default: ;
      endcase
    end

    // Scan steps.
    if (cmd.step) begin
      if (idx_r != LAST_I) idx_nxt = idx_r + IW'(1);
      else idx_nxt = '0;
      unique case (cmd.scan)
        SC_FREE: begin
          if (hit) begin
            stat_nxt[idx_r] = ST_READY; grp_nxt[idx_r] = w_r.group_id;
            flg_nxt[idx_r] = '0; dly_nxt[idx_r] = '0; arg_nxt[idx_r] = '0;
            res_nxt.slot = SLOTO_W'(idx_r);
          end else if (idx_r == LAST_I && !(w_r.op == OP_RECREATE && found_r)) begin
            res_nxt.status = STS_NO_FREE;
          end
        end
        SC_GROUP: begin
          if (hit) res_nxt.slot = SLOTO_W'(idx_r);
          else if (idx_r == LAST_I) begin
            if (w_r.op == OP_FIND) res_nxt.status = STS_NOT_FOUND;
            idx_nxt = '0;
          end
        end
        SC_VICTIM: begin
          if (hit) begin
            stat_nxt[idx_r] = ST_FREE; grp_nxt[idx_r] = '0; res_nxt.matched = 1'b1;
          end
        end
        SC_KILLALL: begin
          if (hit && ((flg_r[idx_r] & pmask_r) == '0)) begin
            stat_nxt[idx_r] = ST_FREE; grp_nxt[idx_r] = '0;
          end
        end
        SC_RECRE: begin
          // Kill victims now; remember a usable slot existed.
          if (hit) found_nxt = 1'b1;
          if (victim) begin
            stat_nxt[idx_r] = ST_FREE; grp_nxt[idx_r] = '0; res_nxt.matched = 1'b1;
          end
          if (idx_r == LAST_I && !(found_r || hit)) begin
            res_nxt.status = STS_NO_FREE;
            // Undo: nothing was killed since no victim existed.
          end
          if (idx_r == LAST_I) idx_nxt = '0;
        end
        SC_DISP: begin
          if (disp_end) begin
            res_nxt.status = STS_WAIT_TICK;
            scan_nxt = END_POS;
          end else begin
            if (scan_r == END_POS) pst_nxt = tick_r;
            if (wake) stat_nxt[idx_r] = ST_READY;
            if (hit) begin
              cv_nxt = 1'b1; cur_nxt = idx_r;
              res_nxt.slot = SLOTO_W'(idx_r);
              scan_nxt = PW'(idx_r) + PW'(1);
            end else begin
              scan_nxt = PW'(idx_r) + PW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        stat_r[k] <= ST_FREE; grp_r[k] <= '0; flg_r[k] <= '0;
        dly_r[k] <= '0; sst_r[k] <= '0; arg_r[k] <= '0;
      end
      cv_r <= 1'b0; cur_r <= '0; scan_r <= END_POS; tick_r <= '0; pst_r <= '0;
      fgrp_r <= '0; pmask_r <= 8'd1; found_r <= 1'b0;
    end else begin
      stat_r <= stat_nxt; grp_r <= grp_nxt; flg_r <= flg_nxt; dly_r <= dly_nxt;
      sst_r <= sst_nxt; arg_r <= arg_nxt;
      cv_r <= cv_nxt; cur_r <= cur_nxt; scan_r <= scan_nxt; tick_r <= tick_nxt;
      pst_r <= pst_nxt; fgrp_r <= fgrp_nxt; pmask_r <= pmask_nxt;
      found_r <= found_nxt;
    end
    w_r <= w_nxt; idx_r <= idx_nxt; res_r <= res_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/task_table_round_robin_scheduler_unit.sv =====
// Top level of the task table round robin scheduler.
// Depends on ttrr_pkg, ttrr_if, ttrr_ctrl and ttrr_dp.
`timescale 1ns / 1ps
`default_nettype none
// One operation word goes in, one result word comes out. Simple operations
// do not walk the table; create, find, kill and recreate walk the slot table one
// slot a cycle (up to two walks), and dispatch walks from the slot after the
// last one picked, one slot a cycle, up to one wrap. The result sits in an
// output register until taken.
module task_table_round_robin_scheduler_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ttrr_if.sink in_ch,
  ttrr_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [ttrr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ttrr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ttrr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  out_word_t res;
  logic busy, done, in_fire, out_v_r;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;

  ttrr_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_op(in_ch.data.op), .out_free(!out_v_r || out_ch.ready),
    .sts, .cmd, .busy, .done
  );

  ttrr_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk, .rst_n, .in_word(in_ch.data), .cmd, .cfg_we, .cfg_idx, .cfg_data,
    .sts, .res
  );

  // Output register.
  out_word_t out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (done) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
    if (done) out_r <= res;
  end
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;
endmodule
`default_nettype wire
